// ----- hw/rtl/csfa_pkg.sv -----
// shared types, constants and the multiply step schedule of the spatial force accumulator
`default_nettype none

package csfa_pkg;

  localparam int unsigned VEC_W  = 32;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned ACC_W  = 66;
  localparam int unsigned SUM_W  = 64;
  localparam int unsigned OUT_W  = 48;
  localparam int unsigned STEP_W = 4;

  localparam logic [STEP_W-1:0] TORQUE_STEP0 = 4'd9;
  localparam logic [STEP_W-1:0] LAST_STEP    = 4'd14;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_ATOM = 1'b1;

  localparam logic [1:0] ROW_LAST = 2'd2;

  // right shifts that bring the exact sums back to Q16.16
  localparam int unsigned ROT_SHIFT = 30;
  localparam int unsigned TRQ_SHIFT = 16;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // one multiply step: operand selects and the group it belongs to
  typedef struct packed {
    logic       trq;    // 0 rotation row, 1 torque component
    logic [1:0] comp;   // row or component index
    logic [3:0] a_idx;  // matrix entry (rotation) or position index (torque)
    logic [1:0] b_idx;  // force index (rotation) or rotated force index (torque)
    logic       first;
    logic       last;
    logic       neg;
  } step_t;

  function automatic step_t step_info(input logic [STEP_W-1:0] s);
    step_t i;
    i = '0;
    unique case (s)
      4'd0:  i = '{1'b0, 2'd0, 4'd0, 2'd0, 1'b1, 1'b0, 1'b0};
      4'd1:  i = '{1'b0, 2'd0, 4'd1, 2'd1, 1'b0, 1'b0, 1'b0};
      4'd2:  i = '{1'b0, 2'd0, 4'd2, 2'd2, 1'b0, 1'b1, 1'b0};
      4'd3:  i = '{1'b0, 2'd1, 4'd3, 2'd0, 1'b1, 1'b0, 1'b0};
      4'd4:  i = '{1'b0, 2'd1, 4'd4, 2'd1, 1'b0, 1'b0, 1'b0};
      4'd5:  i = '{1'b0, 2'd1, 4'd5, 2'd2, 1'b0, 1'b1, 1'b0};
      4'd6:  i = '{1'b0, 2'd2, 4'd6, 2'd0, 1'b1, 1'b0, 1'b0};
      4'd7:  i = '{1'b0, 2'd2, 4'd7, 2'd1, 1'b0, 1'b0, 1'b0};
      4'd8:  i = '{1'b0, 2'd2, 4'd8, 2'd2, 1'b0, 1'b1, 1'b0};
      // torque x = y*fz - z*fy
      4'd9:  i = '{1'b1, 2'd0, 4'd1, 2'd2, 1'b1, 1'b0, 1'b0};
      4'd10: i = '{1'b1, 2'd0, 4'd2, 2'd1, 1'b0, 1'b1, 1'b1};
      // torque y = z*fx - x*fz
      4'd11: i = '{1'b1, 2'd1, 4'd2, 2'd0, 1'b1, 1'b0, 1'b0};
      4'd12: i = '{1'b1, 2'd1, 4'd0, 2'd2, 1'b0, 1'b1, 1'b1};
      // torque z = x*fy - y*fx
      4'd13: i = '{1'b1, 2'd2, 4'd0, 2'd1, 1'b1, 1'b0, 1'b0};
      4'd14: i = '{1'b1, 2'd2, 4'd1, 2'd0, 1'b0, 1'b1, 1'b1};
      default: i = '0;
    endcase
    return i;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cluster_spatial_force_accumulator.sv -----
// top level: cluster 6d spatial force accumulator on one shared multiplier
//
// Takes a stream of words. A load word (func 0) writes one row of the 3x3
// Q2.30 rotation matrix; row 3 is dropped. An atom word (func 1) rotates
// the Q16.16 force by the matrix, adds it to the force sum and adds
// pos x rotated force to the torque sum, all with 64-bit saturating
// sums. The fifteen products run one per cycle, but for the torque wait,
// through a single registered 32x32 multiplier, followed by an accumulate
// stage and a finalize stage (floor shift, clamp, saturating add). The
// torque products wait for the last rotated force component, so an atom
// word holds the block through accept, 9 rotation products, a wait, 6
// torque products and a drain; a word marked last_atom then goes on to move
// the sums, clamped to 48-bit Q32.16, into the output register and clear them,
// and waits there for as long as the output register holds a word not yet taken.
// The output register lets the next word in while a result is still waiting.
`default_nettype none

module cluster_spatial_force_accumulator (
  input  wire logic                clk,
  input  wire logic                rst_n,

  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_func,
  input  wire logic [1:0]          in_row,
  input  wire logic signed [31:0]  in_vec_a,
  input  wire logic signed [31:0]  in_vec_b,
  input  wire logic signed [31:0]  in_vec_c,
  input  wire logic signed [31:0]  in_pos_x,
  input  wire logic signed [31:0]  in_pos_y,
  input  wire logic signed [31:0]  in_pos_z,
  input  wire logic                in_last_atom,

  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [47:0]       out_torque_x,
  output logic signed [47:0]       out_torque_y,
  output logic signed [47:0]       out_torque_z,
  output logic signed [47:0]       out_sum_force_x,
  output logic signed [47:0]       out_sum_force_y,
  output logic signed [47:0]       out_sum_force_z
);

  localparam int unsigned VW = csfa_pkg::VEC_W;
  localparam int unsigned PW = csfa_pkg::PROD_W;
  localparam int unsigned AW = csfa_pkg::ACC_W;
  localparam int unsigned SW = csfa_pkg::SUM_W;
  localparam int unsigned OW = csfa_pkg::OUT_W;
  localparam int unsigned TW = csfa_pkg::STEP_W;

  localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [OW-1:0] OUT_MAX = {1'b0, {(OW-1){1'b1}}};
  localparam logic signed [OW-1:0] OUT_MIN = {1'b1, {(OW-1){1'b0}}};
  localparam logic signed [VW-1:0] VEC_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VEC_MIN = {1'b1, {(VW-1){1'b0}}};

  // ---------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------
  csfa_pkg::state_t state_r, state_nxt;

  // rotation matrix, row-major, kept across clusters
  logic signed [VW-1:0] mat_r [9];

  // latched atom word
  logic signed [VW-1:0] f_r [3];
  logic signed [VW-1:0] p_r [3];
  logic                 last_r;

  // rotated force of the current atom
  logic signed [VW-1:0] rv_r [3];

  // running sums
  logic signed [SW-1:0] force_sum_r  [3];
  logic signed [SW-1:0] torque_sum_r [3];

  // sequencer
  logic [TW-1:0] s_r;
  logic          iss_done_r;
  logic          rot_ready_r;   // all three rotated components are in rv_r

  // multiply stage
  logic                 p_vld_r;
  csfa_pkg::step_t      p_info_r;
  logic signed [PW-1:0] prod_r;

  // accumulate stage
  logic                 fin_vld_r;
  logic                 fin_trq_r;
  logic [1:0]           fin_comp_r;
  logic signed [AW-1:0] acc_r;

  // output register
  logic                 out_valid_r;
  logic signed [OW-1:0] out_trq_r [3];
  logic signed [OW-1:0] out_frc_r [3];

  // ---------------------------------------------------------------------
  // handshake
  // ---------------------------------------------------------------------
  logic in_acc;
  logic out_load;

  assign in_stall = (state_r != csfa_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == csfa_pkg::ST_EMIT) && (!out_valid_r || !out_stall);

  // ---------------------------------------------------------------------
  // issue: one product per cycle, unless waiting for the rotated force, into the shared multiplier
  // ---------------------------------------------------------------------
  csfa_pkg::step_t      iss_info;
  logic                 iss_go;
  logic signed [VW-1:0] op_a;
  logic signed [VW-1:0] op_b;

  assign iss_info = csfa_pkg::step_info(s_r);
  // torque products need the finished rotated force
  assign iss_go   = (state_r == csfa_pkg::ST_RUN) && !iss_done_r &&
                    !(s_r == csfa_pkg::TORQUE_STEP0 && !rot_ready_r);

  always_comb begin
    if (iss_info.trq) begin
      op_a = p_r[iss_info.a_idx[1:0]];
      op_b = rv_r[iss_info.b_idx];
    end else begin
      op_a = mat_r[iss_info.a_idx];
      op_b = f_r[iss_info.b_idx];
    end
  end

  // ---------------------------------------------------------------------
  // accumulate: exact sum of the group's products
  // ---------------------------------------------------------------------
  logic signed [AW-1:0] term;
  logic signed [AW-1:0] acc_nxt;

  always_comb begin
    term    = AW'(prod_r);
    if (p_info_r.neg) begin
      term = -term;
    end
    acc_nxt = (p_info_r.first ? '0 : acc_r) + term;
  end

  // ---------------------------------------------------------------------
  // finalize: floor shift, clamp, shared saturating 64-bit add
  // ---------------------------------------------------------------------
  logic signed [AW-1:0] rot_sh;
  logic signed [AW-1:0] trq_sh;
  logic signed [VW-1:0] rot_sat;
  logic signed [SW-1:0] add_base;
  logic signed [SW-1:0] add_term;
  logic signed [SW:0]   add_wide;
  logic signed [SW-1:0] add_res;

  assign rot_sh = acc_r >>> csfa_pkg::ROT_SHIFT;
  assign trq_sh = acc_r >>> csfa_pkg::TRQ_SHIFT;

  always_comb begin
    if (rot_sh > AW'(VEC_MAX)) begin
      rot_sat = VEC_MAX;
    end else if (rot_sh < AW'(VEC_MIN)) begin
      rot_sat = VEC_MIN;
    end else begin
      rot_sat = rot_sh[VW-1:0];
    end
  end

  always_comb begin
    if (fin_trq_r) begin
      add_base = torque_sum_r[fin_comp_r];
      // the torque difference fits well inside 64 bits after the shift
      add_term = trq_sh[SW-1:0];
    end else begin
      add_base = force_sum_r[fin_comp_r];
      add_term = SW'(rot_sat);
    end
    add_wide = {add_base[SW-1], add_base} + {add_term[SW-1], add_term};
    if (add_wide[SW] != add_wide[SW-1]) begin
      add_res = add_wide[SW] ? SUM_MIN : SUM_MAX;
    end else begin
      add_res = add_wide[SW-1:0];
    end
  end

  // last torque component finished
  logic fin_end;
  assign fin_end = fin_vld_r && fin_trq_r && (fin_comp_r == csfa_pkg::ROW_LAST);

  // ---------------------------------------------------------------------
  // state machine
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      csfa_pkg::ST_IDLE: begin
        if (in_acc && in_func == csfa_pkg::FUNC_ATOM) begin
          state_nxt = csfa_pkg::ST_RUN;
        end
      end
      csfa_pkg::ST_RUN: begin
        if (fin_end) begin
          state_nxt = last_r ? csfa_pkg::ST_EMIT : csfa_pkg::ST_IDLE;
        end
      end
      csfa_pkg::ST_EMIT: begin
        if (out_load) begin
          state_nxt = csfa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = csfa_pkg::ST_IDLE;
    endcase
  end

  // output clamp to 48 bits
  function automatic logic signed [OW-1:0] clamp_out(input logic signed [SW-1:0] v);
    logic signed [OW-1:0] r;
    if (v > SW'(OUT_MAX)) begin
      r = OUT_MAX;
    end else if (v < SW'(OUT_MIN)) begin
      r = OUT_MIN;
    end else begin
      r = v[OW-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csfa_pkg::ST_IDLE;
      s_r         <= '0;
      iss_done_r  <= 1'b0;
      rot_ready_r <= 1'b0;
      p_vld_r     <= 1'b0;
      fin_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      p_vld_r   <= iss_go;
      fin_vld_r <= p_vld_r && p_info_r.last;
      if (in_acc && in_func == csfa_pkg::FUNC_ATOM) begin
        s_r         <= '0;
        iss_done_r  <= 1'b0;
        rot_ready_r <= 1'b0;
      end else begin
        if (iss_go) begin
          s_r <= s_r + 1'b1;
          if (s_r == csfa_pkg::LAST_STEP) begin
            iss_done_r <= 1'b1;
          end
        end
        if (fin_vld_r && !fin_trq_r && fin_comp_r == csfa_pkg::ROW_LAST) begin
          rot_ready_r <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // matrix and sums carry reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        mat_r[i] <= '0;
      end
      for (int k = 0; k < 3; k++) begin
        force_sum_r[k]  <= '0;
        torque_sum_r[k] <= '0;
      end
    end else begin
      if (in_acc && in_func == csfa_pkg::FUNC_LOAD && in_row <= csfa_pkg::ROW_LAST) begin
        mat_r[4'(3 * in_row)]     <= in_vec_a;
        mat_r[4'(3 * in_row + 1)] <= in_vec_b;
        mat_r[4'(3 * in_row + 2)] <= in_vec_c;
      end
      if (out_load) begin
        for (int k = 0; k < 3; k++) begin
          force_sum_r[k]  <= '0;
          torque_sum_r[k] <= '0;
        end
      end else if (fin_vld_r) begin
        if (fin_trq_r) begin
          torque_sum_r[fin_comp_r] <= add_res;
        end else begin
          force_sum_r[fin_comp_r] <= add_res;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc && in_func == csfa_pkg::FUNC_ATOM) begin
      f_r[0] <= in_vec_a;
      f_r[1] <= in_vec_b;
      f_r[2] <= in_vec_c;
      p_r[0] <= in_pos_x;
      p_r[1] <= in_pos_y;
      p_r[2] <= in_pos_z;
      last_r <= in_last_atom;
    end
    if (iss_go) begin
      prod_r   <= op_a * op_b;
      p_info_r <= iss_info;
    end
    if (p_vld_r) begin
      acc_r      <= acc_nxt;
      fin_trq_r  <= p_info_r.trq;
      fin_comp_r <= p_info_r.comp;
    end
    if (fin_vld_r && !fin_trq_r) begin
      rv_r[fin_comp_r] <= rot_sat;
    end
    if (out_load) begin
      for (int k = 0; k < 3; k++) begin
        out_trq_r[k] <= clamp_out(torque_sum_r[k]);
        out_frc_r[k] <= clamp_out(force_sum_r[k]);
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_torque_x    = out_trq_r[0];
  assign out_torque_y    = out_trq_r[1];
  assign out_torque_z    = out_trq_r[2];
  assign out_sum_force_x = out_frc_r[0];
  assign out_sum_force_y = out_frc_r[1];
  assign out_sum_force_z = out_frc_r[2];

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_fin_in_run : assert property (@(posedge clk) disable iff (!rst_n)
    fin_vld_r |-> state_r == csfa_pkg::ST_RUN)
    else $error("finalize outside of an atom run");

  a_trq_after_rot : assert property (@(posedge clk) disable iff (!rst_n)
    (p_vld_r && p_info_r.trq) |-> rot_ready_r)
    else $error("torque product issued before rotated force was complete");

  a_out_from_emit : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == csfa_pkg::ST_EMIT))
    else $error("result word raised outside the emit state");

  a_sums_cleared : assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (force_sum_r[0] == '0 && torque_sum_r[2] == '0))
    else $error("sums not cleared after a result");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// self-checking testbench for the spatial force accumulator, directed table then random clusters
module tb;

  localparam int unsigned VEC_W     = csfa_pkg::VEC_W;
  localparam int unsigned OUT_W     = csfa_pkg::OUT_W;
  localparam int unsigned ROT_SHIFT = csfa_pkg::ROT_SHIFT;
  localparam int unsigned TRQ_SHIFT = csfa_pkg::TRQ_SHIFT;
  localparam logic        FUNC_LOAD = csfa_pkg::FUNC_LOAD;
  localparam logic        FUNC_ATOM = csfa_pkg::FUNC_ATOM;
  localparam logic [1:0]  ROW_LAST  = csfa_pkg::ROW_LAST;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_WORDS = 1330;
  localparam int unsigned HOLD_CYCLES  = 300;   // one long output hold-off, fills the block
  localparam int unsigned HOLD_AFTER   = 40;    // results seen before the hold-off starts
  localparam int unsigned DRAIN_CYCLES = 40;    // room for an atom plus emit, with margin

  localparam logic [1:0]       ROW_NONE = 2'd3; // no such matrix row, the load is dropped
  localparam logic [VEC_W-1:0] Q_MIN    = 32'h8000_0000;
  localparam logic [VEC_W-1:0] Q_MAX    = 32'h7FFF_FFFF;
  localparam logic [VEC_W-1:0] Q16_ONE  = 32'h0001_0000;
  localparam logic [VEC_W-1:0] Q30_ONE  = 32'h4000_0000;

  // one input word as it goes over the in_ channel
  typedef struct packed {
    logic             func;
    logic [1:0]       row;
    logic [VEC_W-1:0] va, vb, vc;
    logic [VEC_W-1:0] px, py, pz;
    logic             last;
  } word_t;

  // one cluster result: [0..2] torque x/y/z, [3..5] force x/y/z
  typedef logic [5:0][OUT_W-1:0] wrench_t;

  typedef struct packed {
    word_t   w;
    logic    typed;   // expected result written into the table by hand
    wrench_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                    in_valid;
  logic                    in_stall;
  logic                    in_func;
  logic [1:0]              in_row;
  logic signed [VEC_W-1:0] in_vec_a, in_vec_b, in_vec_c;
  logic signed [VEC_W-1:0] in_pos_x, in_pos_y, in_pos_z;
  logic                    in_last_atom;

  logic                    out_valid;
  logic                    out_stall;
  logic signed [OUT_W-1:0] out_torque_x, out_torque_y, out_torque_z;
  logic signed [OUT_W-1:0] out_sum_force_x, out_sum_force_y, out_sum_force_z;

  // predictor state: matrix, open torque and force sums
  logic signed [VEC_W-1:0] rot_m [0:8];
  logic signed [63:0]      torque_acc [0:2];
  logic signed [63:0]      force_acc [0:2];

  wrench_t  pending_wrenches [$];   // cluster results still owed by the block
  dir_row_t dir_rows [$];
  wrench_t  seen_wrench, due_wrench;

  int unsigned err_cnt        = 0;
  int unsigned results_seen   = 0;
  int unsigned counted        = 0;  // words that do something, dropped loads excluded
  int unsigned atom_cnt       = 0;
  int unsigned load_cnt       = 0;
  int unsigned dropped_cnt    = 0;
  int unsigned in_stall_cnt   = 0;
  int unsigned cycle_cnt      = 0;
  bit          pressure_on    = 1'b0;
  bit          pressure_done  = 1'b0;

  cluster_spatial_force_accumulator DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_row          (in_row),
    .in_vec_a        (in_vec_a),
    .in_vec_b        (in_vec_b),
    .in_vec_c        (in_vec_c),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_last_atom    (in_last_atom),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_torque_x    (out_torque_x),
    .out_torque_y    (out_torque_y),
    .out_torque_z    (out_torque_z),
    .out_sum_force_x (out_sum_force_x),
    .out_sum_force_y (out_sum_force_y),
    .out_sum_force_z (out_sum_force_z)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // exact rotation sum back to Q16.16, clamped to 32 bits
  function automatic logic signed [VEC_W-1:0] clamp_q16(input logic signed [65:0] v);
    if (v[65:31] == '0 || v[65:31] == '1) return v[31:0];
    return v[65] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
  endfunction

  // 64-bit add that sticks at the rails
  function automatic logic signed [63:0] add_sat64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s;
  endfunction

  // running sum to the 48-bit Q32.16 output
  function automatic logic [OUT_W-1:0] clamp_out(input logic signed [63:0] v);
    if (v[63:47] == '0 || v[63:47] == '1) return v[47:0];
    return v[63] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
  endfunction

  // load a row, or rotate, cross and accumulate one atom; 1 when a cluster closes
  function automatic bit accumulate_word(input word_t w, output wrench_t wrench);
    logic signed [VEC_W-1:0] f [0:2];
    logic signed [VEC_W-1:0] p [0:2];
    logic signed [VEC_W-1:0] r [0:2];
    logic signed [65:0]      acc;
    logic signed [65:0]      trq_diff;
    logic signed [63:0]      r64;
    int                      k, a, b, base;
    wrench = '0;
    f[0] = w.va;
    f[1] = w.vb;
    f[2] = w.vc;
    if (w.func == FUNC_LOAD) begin
      // a load never touches the sums; row 3 goes nowhere
      if (w.row != ROW_NONE) begin
        base = w.row * 3;
        for (k = 0; k < 3; k++) rot_m[base + k] = f[k];
      end
      return 1'b0;
    end
    p[0] = w.px;
    p[1] = w.py;
    p[2] = w.pz;
    // rotated force: three Q18.46 products summed exactly, floor shift, clamp
    for (k = 0; k < 3; k++) begin
      acc  = rot_m[3*k] * f[0] + rot_m[3*k+1] * f[1] + rot_m[3*k+2] * f[2];
      r[k] = clamp_q16(acc >>> ROT_SHIFT);
    end
    // torque k = p[k+1] * r[k+2] - p[k+2] * r[k+1], exact then floor shift
    for (k = 0; k < 3; k++) begin
      a        = (k + 1) % 3;
      b        = (k + 2) % 3;
      trq_diff = p[a] * r[b] - p[b] * r[a];
      trq_diff = trq_diff >>> TRQ_SHIFT;
      r64      = r[k];
      torque_acc[k] = add_sat64(torque_acc[k], trq_diff[63:0]);
      force_acc[k]  = add_sat64(force_acc[k], r64);
    end
    if (!w.last) return 1'b0;
    for (k = 0; k < 3; k++) begin
      wrench[k]     = clamp_out(torque_acc[k]);
      wrench[3 + k] = clamp_out(force_acc[k]);
      torque_acc[k] = '0;
      force_acc[k]  = '0;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // word and value builders
  // ---------------------------------------------------------------------------

  function automatic word_t mk_word(input logic func, input logic [1:0] row,
                                    input logic [VEC_W-1:0] a, input logic [VEC_W-1:0] b,
                                    input logic [VEC_W-1:0] c, input logic [VEC_W-1:0] x,
                                    input logic [VEC_W-1:0] y, input logic [VEC_W-1:0] z,
                                    input logic last);
    return {func, row, a, b, c, x, y, z, last};
  endfunction

  function automatic wrench_t mk_wrench(input logic [OUT_W-1:0] tx, input logic [OUT_W-1:0] ty,
                                        input logic [OUT_W-1:0] tz, input logic [OUT_W-1:0] fx,
                                        input logic [OUT_W-1:0] fy, input logic [OUT_W-1:0] fz);
    return {fz, fy, fx, tz, ty, tx};
  endfunction

  // force or coordinate: rails, zero, small values around the origin, full range
  function automatic logic [VEC_W-1:0] pick_q16();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return Q_MIN;
    if (sel == 1) return Q_MAX;
    if (sel == 2) return '0;
    if (sel <= 5) return $urandom_range(0, 32'h000F_FFFF) - 32'h0007_FFFF;  // within +-8.0
    return $urandom();
  endfunction

  // matrix entry: mostly a plausible rotation entry within +-1.0
  function automatic logic [VEC_W-1:0] pick_q230();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return Q_MIN;
    if (sel == 1) return Q_MAX;
    if (sel == 2) return '0;
    if (sel <= 7) return $urandom_range(0, 32'h8000_0000) - Q30_ONE;
    return $urandom();
  endfunction

  function automatic word_t random_load(input logic [1:0] row);
    return mk_word(FUNC_LOAD, row, pick_q230(), pick_q230(), pick_q230(),
                   $urandom(), $urandom(), $urandom(), 1'($urandom_range(0, 1)));
  endfunction

  function automatic word_t random_atom(input logic last);
    return mk_word(FUNC_ATOM, 2'($urandom_range(0, 3)), pick_q16(), pick_q16(), pick_q16(),
                   pick_q16(), pick_q16(), pick_q16(), last);
  endfunction

  function automatic string field_name(input int k);
    case (k)
      0: return "torque_x";
      1: return "torque_y";
      2: return "torque_z";
      3: return "sum_force_x";
      4: return "sum_force_y";
      default: return "sum_force_z";
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // sender gap: mostly none or short, a few long; none while the output is held
  // off and during a quiet stretch of back-to-back words
  function automatic int unsigned pick_gap();
    int unsigned sel;
    if (pressure_on || (counted >= 300 && counted < 420)) return 0;
    sel = $urandom_range(0, 19);
    if (sel < 10) return 0;
    if (sel < 17) return $urandom_range(1, 3);
    if (sel < 19) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic table_row(input word_t w, input logic typed, input wrench_t want);
    dir_rows.push_back({w, typed, want});
  endtask

  // offer one word, hold it until taken, then predict what it owes
  task automatic push_word(input word_t w, input logic typed, input wrench_t want);
    int unsigned gap;
    wrench_t     wrench;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= w.func;
    in_row       <= w.row;
    in_vec_a     <= w.va;
    in_vec_b     <= w.vb;
    in_vec_c     <= w.vc;
    in_pos_x     <= w.px;
    in_pos_y     <= w.py;
    in_pos_z     <= w.pz;
    in_last_atom <= w.last;
    @(posedge clk);
    while (in_stall) begin
      in_stall_cnt++;
      @(posedge clk);
    end
    if (accumulate_word(w, wrench)) pending_wrenches.push_back(typed ? want : wrench);
    if (w.func == FUNC_ATOM) begin
      atom_cnt++;
      counted++;
    end else if (w.row == ROW_NONE) begin
      dropped_cnt++;
    end else begin
      load_cnt++;
      counted++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // output side
  // ---------------------------------------------------------------------------

  // stall runs of random length; once, a long hold-off so the block backs up
  initial begin : drive_out_stall
    int unsigned sel, run;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!pressure_done && results_seen >= HOLD_AFTER) begin
        pressure_done = 1'b1;
        pressure_on   = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        pressure_on   = 1'b0;
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
          out_stall <= 1'b0;
          run = $urandom_range(1, 30);
        end else if (sel < 90) begin
          out_stall <= 1'b1;
          run = $urandom_range(1, 3);
        end else if (sel < 98) begin
          out_stall <= 1'b1;
          run = $urandom_range(4, 20);
        end else begin
          out_stall <= 1'b1;
          run = $urandom_range(30, 80);
        end
        repeat (run) @(posedge clk);
      end
    end
  end

  // every taken result against the oldest owed one, field by field
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_wrench = {out_sum_force_z, out_sum_force_y, out_sum_force_x,
                     out_torque_z, out_torque_y, out_torque_x};
      if (pending_wrenches.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual torque %h %h %h force %h %h %h",
                 $time, seen_wrench[0], seen_wrench[1], seen_wrench[2],
                 seen_wrench[3], seen_wrench[4], seen_wrench[5]);
        err_cnt++;
      end else begin
        due_wrench = pending_wrenches.pop_front();
        for (int k = 0; k < 6; k++) begin
          if (seen_wrench[k] !== due_wrench[k]) begin
            $display("%0t: %s mismatch, expected %h actual %h",
                     $time, field_name(k), due_wrench[k], seen_wrench[k]);
            err_cnt++;
          end
        end
      end
      results_seen++;
    end
  end

  // hard stop if the block hangs
  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results still owed", cycle_cnt,
             pending_wrenches.size());
    $display("cluster_spatial_force_accumulator regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int unsigned i, n, first, base;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_func      = FUNC_LOAD;
    in_row       = '0;
    in_vec_a     = '0;
    in_vec_b     = '0;
    in_vec_c     = '0;
    in_pos_x     = '0;
    in_pos_y     = '0;
    in_pos_z     = '0;
    in_last_atom = 1'b0;
    for (i = 0; i < 9; i++) rot_m[i] = '0;
    for (i = 0; i < 3; i++) begin
      torque_acc[i] = '0;
      force_acc[i]  = '0;
    end

    // matrix is all zero out of reset, so even full-scale force gives nothing
    table_row(mk_word(FUNC_ATOM, 2'd0, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 1'b1),
              1'b1, '0);
    // identity matrix, one row per word
    table_row(mk_word(FUNC_LOAD, 2'd0, Q30_ONE, 0, 0, 0, 0, 0, 1'b0), 1'b0, '0);
    table_row(mk_word(FUNC_LOAD, 2'd1, 0, Q30_ONE, 0, 0, 0, 0, 1'b0), 1'b0, '0);
    table_row(mk_word(FUNC_LOAD, ROW_LAST, 0, 0, Q30_ONE, 0, 0, 0, 1'b0), 1'b0, '0);
    // row 3 does not exist, the all-ones payload must not land anywhere
    table_row(mk_word(FUNC_LOAD, ROW_NONE, '1, '1, '1, '1, '1, '1, 1'b1), 1'b0, '0);
    // unit force along x at unit y: torque of -1 about z
    table_row(mk_word(FUNC_ATOM, 2'd0, Q16_ONE, 0, 0, 0, Q16_ONE, 0, 1'b1), 1'b1,
              mk_wrench('0, '0, 48'hFFFF_FFFF_0000, 48'h0000_0001_0000, '0, '0));
    // an open cluster emits nothing until its last atom
    table_row(mk_word(FUNC_ATOM, ROW_NONE, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1'b0),
              1'b0, '0);
    table_row(mk_word(FUNC_ATOM, 2'd1, Q_MIN, Q_MAX, 1, Q16_ONE, Q16_ONE, Q16_ONE, 1'b1),
              1'b0, '0);
    // every entry -2.0; last and position on a load are ignored
    for (i = 0; i < 3; i++)
      table_row(mk_word(FUNC_LOAD, 2'(i), Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b1),
                1'b0, '0);
    // rotated force clamps at the 32-bit rails, high then low
    table_row(mk_word(FUNC_ATOM, 2'd0, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 1'b1), 1'b1,
              mk_wrench('0, '0, '0, 48'h0000_7FFF_FFFF, 48'h0000_7FFF_FFFF,
                        48'h0000_7FFF_FFFF));
    table_row(mk_word(FUNC_ATOM, 2'd0, Q_MAX, Q_MAX, Q_MAX, 0, 0, 0, 1'b1), 1'b1,
              mk_wrench('0, '0, '0, 48'hFFFF_8000_0000, 48'hFFFF_8000_0000,
                        48'hFFFF_8000_0000));
    // two full-scale torques push the 48-bit output onto its rails
    table_row(mk_word(FUNC_ATOM, 2'd0, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, 1'b0),
              1'b0, '0);
    table_row(mk_word(FUNC_ATOM, 2'd0, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, 1'b1),
              1'b0, '0);
    table_row(mk_word(FUNC_ATOM, 2'd2, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MAX, 1'b0),
              1'b0, '0);
    table_row(mk_word(FUNC_ATOM, 2'd2, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MAX, 1'b1),
              1'b0, '0);
    // every entry just under +2.0
    for (i = 0; i < 3; i++)
      table_row(mk_word(FUNC_LOAD, 2'(i), Q_MAX, Q_MAX, Q_MAX, 0, 0, 0, 1'b0), 1'b0, '0);
    table_row(mk_word(FUNC_ATOM, 2'd3, Q_MAX, Q_MIN, Q16_ONE, Q_MAX, Q_MIN, 0, 1'b1), 1'b0, '0);
    // the matrix stays loaded into the next cluster
    table_row(mk_word(FUNC_ATOM, 2'd0, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q16_ONE, 1'b1),
              1'b0, '0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[j]) push_word(dir_rows[j].w, dir_rows[j].typed, dir_rows[j].want);

    // random clusters: usually a fresh matrix, then a handful of atoms closed by
    // a last atom; some stray words and mid-cluster reloads mixed in
    base = counted;
    while (counted - base < RANDOM_WORDS) begin
      if ($urandom_range(0, 9) == 0) begin
        push_word(mk_word(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                          $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                          $urandom(), 1'($urandom_range(0, 1))), 1'b0, '0);
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          first = $urandom_range(0, 2);
          for (i = 0; i < 3; i++) push_word(random_load(2'((first + i) % 3)), 1'b0, '0);
        end
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30) : $urandom_range(1, 6);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(0, 11) == 0)
            push_word(random_load(2'($urandom_range(0, 3))), 1'b0, '0);
          push_word(random_atom(i == n - 1), 1'b0, '0);
        end
      end
    end
    in_valid <= 1'b0;

    // wait for every owed result, then watch a little longer for strays
    while (pending_wrenches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d atom words and %0d matrix row loads (%0d row-3 loads dropped)",
             atom_cnt, load_cnt, dropped_cnt);
    $display("checked %0d cluster results, %0d mismatches, input stalled %0d cycles",
             results_seen, err_cnt, in_stall_cnt);
    if (err_cnt == 0) begin
      $display("cluster_spatial_force_accumulator regression: pass");
    end else begin
      $display("cluster_spatial_force_accumulator regression: fail");
    end
    $finish;
  end

endmodule

// ----- cluster_spatial_force_accumulator.f -----
hw/rtl/csfa_pkg.sv
hw/rtl/cluster_spatial_force_accumulator.sv
tb/tb.sv
